@@ rtl/rhi_pkg.sv @@
package rhi_pkg;

  localparam int INDEX_BITS = 16;
  localparam int FRAC_BITS  = 24;
  localparam int MAX_BASE   = 16;

  // Port widths
  localparam int INDEX_W    = 16;
  localparam int BASE_W     = 5;
  localparam int FRACTION_W = 24;
  localparam int COUNT_W    = 5;

  // One cell per index bit that takes part
  localparam int CHAIN_LEN = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;
  // Running remainder of a digit division stays below the base
  localparam int REM_W     = $clog2(MAX_BASE);
  localparam int CMP_W     = (REM_W + 1 > BASE_W) ? REM_W + 1 : BASE_W;
  // Base power exceeds the index by less than one factor of the base
  localparam int POW_W     = CHAIN_LEN + REM_W;
  localparam int QCNT_W    = $clog2(FRAC_BITS + 1);
  localparam int FRAC_WIDE = (FRAC_BITS > FRACTION_W) ? FRAC_BITS : FRACTION_W;

  // Data handed from one cell to the next
  typedef struct packed {
    logic             vld;
    logic             nz;
    logic [REM_W-1:0] rem;
  } link_t;

endpackage

@@ rtl/rhi_cell.sv @@
module rhi_cell import rhi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              load_bit,
  input  logic [BASE_W-1:0] base,
  input  link_t             link_in,
  output link_t             link_out
);

  logic             qbit;
  logic             vld;
  logic             nz;
  logic [REM_W-1:0] rem;

  logic [CMP_W-1:0] trial;
  logic [CMP_W-1:0] base_ext;
  logic [CMP_W-1:0] diff;
  logic             fits;

  // One long-division step: bring this bit down under the remainder
  always_comb begin
    trial    = CMP_W'({link_in.rem, qbit});
    base_ext = CMP_W'(base);
    fits     = (trial >= base_ext);
    diff     = trial - base_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= 1'b0;
    end else begin
      vld <= link_in.vld;
    end
  end

  // The stored bit becomes the quotient bit for the next wave
  always_ff @(posedge clk) begin
    if (load) begin
      qbit <= load_bit;
    end else if (link_in.vld) begin
      qbit <= fits;
      nz   <= link_in.nz | qbit;
      rem  <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
    end
  end

  assign link_out = '{vld: vld, nz: nz, rem: rem};

endmodule

@@ rtl/rhi_divider.sv @@
module rhi_divider import rhi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [POW_W-1:0]     num,
  input  logic [POW_W-1:0]     den,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quot
);

  logic              active;
  logic [QCNT_W-1:0] steps;
  logic [POW_W-1:0]  rem;

  logic [POW_W:0] trial;
  logic [POW_W:0] den_ext;
  logic [POW_W:0] diff;
  logic           fits;

  always_comb begin
    trial   = {rem, 1'b0};
    den_ext = {1'b0, den};
    fits    = (trial >= den_ext);
    diff    = trial - den_ext;
  end

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        steps  <= QCNT_W'(FRAC_BITS);
        rem    <= num;
        quot   <= '0;
      end else if (active) begin
        rem   <= fits ? diff[POW_W-1:0] : trial[POW_W-1:0];
        quot  <= {quot[FRAC_BITS-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == QCNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/radical_inverse_halton_unit.sv @@
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+------------------------------
// request  | index_value, digit_base                | taken when start && !busy
// result   | fraction, digit_count, bad_base        | one-cycle strobe on done
//
// A request with a valid base (default 16-cell chain, 24-bit fraction) passes from
// acceptance to done through the cell chain, which peels one base digit per cycle
// once every cell has filled, and then through the divider, which yields one
// fraction bit per cycle.
// An out-of-range base returns its result in the next cycle without going busy.
// Synchronous reset clears the control state; results cannot be stalled.
module radical_inverse_halton_unit import rhi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [INDEX_W-1:0]    index_value,
  input  logic [BASE_W-1:0]     digit_base,
  output logic                  done,
  output logic [FRACTION_W-1:0] fraction,
  output logic [COUNT_W-1:0]    digit_count,
  output logic                  bad_base
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIGITS,
    S_DIVIDE
  } state_t;

  state_t state;

  logic              run;
  logic              div_go;
  logic [BASE_W-1:0] base_q;
  logic [POW_W-1:0]  rev;
  logic [POW_W-1:0]  power;
  logic [COUNT_W-1:0] count;

  logic                   accept;
  logic                   base_ok;
  link_t                  links [CHAIN_LEN+1];
  link_t                  chain_out;
  logic [POW_W+BASE_W-1:0] rev_prod;
  logic [POW_W+BASE_W-1:0] pow_prod;
  logic [POW_W-1:0]       rev_next;
  logic                   div_done;
  logic [FRAC_BITS-1:0]   div_quot;
  logic [FRAC_WIDE-1:0]   frac_wide;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign base_ok = (digit_base >= BASE_W'(2)) && (int'(digit_base) <= MAX_BASE);

  // Cell 0 takes the most significant index bit
  assign links[0] = '{vld: run, nz: 1'b0, rem: '0};

  for (genvar j = 0; j < CHAIN_LEN; j++) begin : g_cell
    rhi_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .load     (accept),
      .load_bit (index_value[CHAIN_LEN-1-j]),
      .base     (base_q),
      .link_in  (links[j]),
      .link_out (links[j+1])
    );
  end

  assign chain_out = links[CHAIN_LEN];

  // Append the digit below the reversed value and grow the base power
  assign rev_prod = (POW_W+BASE_W)'(rev) * (POW_W+BASE_W)'(base_q);
  assign pow_prod = (POW_W+BASE_W)'(power) * (POW_W+BASE_W)'(base_q);
  assign rev_next = rev_prod[POW_W-1:0] + POW_W'(chain_out.rem);

  rhi_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (rev),
    .den  (power),
    .done (div_done),
    .quot (div_quot)
  );

  assign frac_wide = FRAC_WIDE'(div_quot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      run    <= 1'b0;
      div_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      div_go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (!base_ok) begin
              done        <= 1'b1;
              bad_base    <= 1'b1;
              fraction    <= '0;
              digit_count <= '0;
            end else begin
              state  <= S_DIGITS;
              run    <= 1'b1;
              base_q <= digit_base;
              rev    <= '0;
              power  <= POW_W'(1);
              count  <= '0;
            end
          end
        end
        S_DIGITS: begin
          if (chain_out.vld) begin
            if (chain_out.nz) begin
              rev   <= rev_next;
              power <= pow_prod[POW_W-1:0];
              count <= count + 1'b1;
            end else begin
              // Quotient reached zero: stop feeding waves, divide
              run    <= 1'b0;
              div_go <= 1'b1;
              state  <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          if (div_done) begin
            fraction    <= frac_wide[FRACTION_W-1:0];
            digit_count <= count;
            bad_base    <= 1'b0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rhi_pkg::*;

  localparam int RANDOM_REQUESTS = 1630;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int MAX_GAP         = 12;
  localparam int N_DIRECTED      = 21;

  typedef struct packed {
    logic [FRACTION_W-1:0] fraction;
    logic [COUNT_W-1:0]    digit_count;
    logic                  bad_base;
  } inverse_t;

  typedef struct packed {
    logic [INDEX_W-1:0] idx;
    logic [BASE_W-1:0]  base;
    logic               typed;
    inverse_t           want;
  } request_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [INDEX_W-1:0]    index_value;
  logic [BASE_W-1:0]     digit_base;
  logic                  done;
  logic [FRACTION_W-1:0] fraction;
  logic [COUNT_W-1:0]    digit_count;
  logic                  bad_base;

  inverse_t pending_inverses[$];
  inverse_t next_inverse;
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       no_gaps = 1'b0;

  // Rows with typed = 1 carry an expectation read straight off the definition
  request_row_t directed_rows [N_DIRECTED] = '{
    '{16'h0000, 5'd2,  1'b1, '{24'h000000, 5'd0,  1'b0}},
    '{16'h0000, 5'd16, 1'b1, '{24'h000000, 5'd0,  1'b0}},
    '{16'h0001, 5'd2,  1'b1, '{24'h800000, 5'd1,  1'b0}},
    '{16'h0001, 5'd16, 1'b1, '{24'h100000, 5'd1,  1'b0}},
    '{16'hFFFF, 5'd2,  1'b1, '{24'hFFFF00, 5'd16, 1'b0}},
    '{16'hFFFF, 5'd16, 1'b1, '{24'hFFFF00, 5'd4,  1'b0}},
    '{16'h8000, 5'd2,  1'b1, '{24'h000100, 5'd16, 1'b0}},
    '{16'h1234, 5'd0,  1'b1, '{24'h000000, 5'd0,  1'b1}},
    '{16'hFFFF, 5'd1,  1'b1, '{24'h000000, 5'd0,  1'b1}},
    '{16'hFFFF, 5'd17, 1'b1, '{24'h000000, 5'd0,  1'b1}},
    '{16'h5555, 5'd31, 1'b1, '{24'h000000, 5'd0,  1'b1}},
    '{16'h0000, 5'd0,  1'b1, '{24'h000000, 5'd0,  1'b1}},
    '{16'hFFFF, 5'd3,  1'b0, '0},
    '{16'hFFFF, 5'd15, 1'b0, '0},
    '{16'hAAAA, 5'd2,  1'b0, '0},
    '{16'h5555, 5'd4,  1'b0, '0},
    '{16'h3039, 5'd10, 1'b0, '0},
    '{16'h0002, 5'd3,  1'b0, '0},
    '{16'h8000, 5'd7,  1'b0, '0},
    '{16'h0001, 5'd15, 1'b0, '0},
    '{16'hFFFF, 5'd9,  1'b0, '0}
  };

  radical_inverse_halton_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .index_value (index_value),
    .digit_base  (digit_base),
    .done        (done),
    .fraction    (fraction),
    .digit_count (digit_count),
    .bad_base    (bad_base)
  );

  always #2 clk = ~clk;

  function automatic inverse_t radical_inverse_of(logic [INDEX_W-1:0] idx,
                                                  logic [BASE_W-1:0] base);
    inverse_t    r;
    logic [63:0] n;
    logic [63:0] rev;
    logic [63:0] power;
    logic [63:0] rem;
    logic [63:0] quot;
    int          count;
    r = '0;
    if (base < 2 || base > MAX_BASE) begin
      r.bad_base = 1'b1;
      return r;
    end
    n = 64'(idx) & ((64'd1 << INDEX_BITS) - 64'd1);
    rev = 0;
    power = 1;
    count = 0;
    while (n != 0) begin
      rev = rev * base + n % base;
      n = n / base;
      power = power * base;
      count++;
    end
    // Restoring division of rev * 2^FRAC_BITS by the base power
    rem = rev;
    quot = 0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      quot = quot << 1;
      if (rem >= power) begin
        rem = rem - power;
        quot[0] = 1'b1;
      end
    end
    r.fraction = quot[FRACTION_W-1:0];
    r.digit_count = COUNT_W'(count);
    return r;
  endfunction

  task automatic note_mismatch(string what, inverse_t want, inverse_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected fraction %h count %0d bad %b, got fraction %h count %0d bad %b",
               $realtime, what, want.fraction, want.digit_count, want.bad_base,
               got.fraction, got.digit_count, got.bad_base);
  endtask

  // Called at a falling edge; returns at a falling edge after the idle gap
  task automatic issue_request(logic [INDEX_W-1:0] idx, logic [BASE_W-1:0] base,
                               inverse_t want);
    int gap;
    next_inverse = want;
    start <= 1'b1;
    index_value <= idx;
    digit_base <= base;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin : result_check
    inverse_t want;
    inverse_t got;
    if (!rst) begin
      got = '{fraction, digit_count, bad_base};
      if (done) begin
        if (pending_inverses.size() == 0) begin
          note_mismatch("result with no request waiting", '0, got);
        end else begin
          want = pending_inverses.pop_front();
          if (got.fraction !== want.fraction || got.digit_count !== want.digit_count ||
              got.bad_base !== want.bad_base)
            note_mismatch("result mismatch", want, got);
        end
      end
      // Queue the request after the result so a same-edge result pairs with an older one
      if (start && !busy)
        pending_inverses.push_back(next_inverse);
      if ((start && !busy) || done)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [INDEX_W-1:0] idx;
    logic [BASE_W-1:0]  base;
    int                 k;
    rst = 1'b1;
    start = 1'b0;
    index_value = '0;
    digit_base = '0;
    next_inverse = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      issue_request(directed_rows[i].idx, directed_rows[i].base,
                    directed_rows[i].typed ? directed_rows[i].want :
                    radical_inverse_of(directed_rows[i].idx, directed_rows[i].base));

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      // Switch between gapped traffic and back-to-back bursts
      if (n % 64 == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        base = $urandom_range(0, 1) ? BASE_W'($urandom_range(0, 1)) :
                                      BASE_W'($urandom_range(MAX_BASE + 1, 31));
      else
        base = BASE_W'($urandom_range(2, MAX_BASE));
      case ($urandom_range(0, 3))
        0: idx = INDEX_W'($urandom);
        1: idx = INDEX_W'($urandom_range(0, 255));
        2: begin
          k = $urandom_range(0, INDEX_W - 1);
          idx = INDEX_W'((32'd1 << k) + $urandom_range(0, 2) - 1);
        end
        default: idx = INDEX_W'(16'hFFFF ^ $urandom_range(0, 255));
      endcase
      issue_request(idx, base, radical_inverse_of(idx, base));
    end
    start <= 1'b0;

    while (pending_inverses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ radical_inverse_halton_unit.f @@
rtl/rhi_pkg.sv
rtl/rhi_cell.sv
rtl/rhi_divider.sv
rtl/radical_inverse_halton_unit.sv
tb/testbench.sv
